// ----- hdl/onewire_uart_rom_sequencer_core_macros.svh -----
// Assertion macros for the 1-Wire over UART ROM sequencer.
// Used by the top level only; no other dependencies.
`ifndef ONEWIRE_UART_ROM_SEQUENCER_CORE_MACROS_SVH
`define ONEWIRE_UART_ROM_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define OWRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owrs assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define OWRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owrs assertion failed");

`endif

// ----- hdl/owrs_pkg.sv -----
// Shared types, codes and CRC-8 helper for the 1-Wire over UART ROM sequencer.
// No dependencies; used by owrs_step, owrs_out_stage and the top level.
package owrs_pkg;

  localparam int unsigned ROM_W  = 56;
  localparam int unsigned CODE_W = 64;

  localparam logic [2:0] OP_RESET    = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_READ_ROM = 3'd3;
  localparam logic [2:0] OP_SKIP_ROM = 3'd4;
  localparam logic [2:0] OP_MATCH    = 3'd5;
  localparam logic [2:0] OP_ECHO     = 3'd6;

  localparam logic [7:0] BYTE_RESET   = 8'hF0;
  localparam logic [7:0] BYTE_ONE     = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] CMD_READ_ROM = 8'h33;
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_MATCH    = 8'h55;

  localparam logic [6:0] SLOTS_BYTE = 7'd8;
  localparam logic [6:0] SLOTS_ROM  = 7'd72;
  localparam logic [5:0] ID_BITS    = 6'd56;

  typedef struct packed {
    logic              busy;
    logic [2:0]        cmd;
    logic [6:0]        slot;
    logic [CODE_W-1:0] shift;
    logic [7:0]        crc;
    logic              fast;
    logic              rst_slot;
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        tx_byte;
    logic              slow_baud;
    logic              success;
    logic [CODE_W-1:0] result_data;
  } result_t;

  // One bit of the reflected Dallas CRC-8 (x^8+x^5+x^4+1).
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic b);
    logic       t;
    logic [7:0] c;
    t = b ^ crc[0];
    c = crc ^ {3'b000, t, t, 3'b000};
    return {t, c[7:1]};
  endfunction

  function automatic logic [7:0] command_byte(logic [2:0] cmd);
    logic [7:0] r;
    case (cmd)
      OP_READ_ROM: r = CMD_READ_ROM;
      OP_SKIP_ROM: r = CMD_SKIP_ROM;
      default:     r = CMD_MATCH;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/onewire_uart_rom_sequencer_core.sv -----
// A result beat passes through the input register, then the result register, and is presented
// once the result register is free to load it; commands and echoes that give no result leave
// the input register as soon as the result register can take a beat.
// Throughput: one input beat per cycle, limited only by the result register draining.
// Reset (rst_n low, synchronous): idle, slow baud, all sequencer state cleared.
`include "onewire_uart_rom_sequencer_core_macros.svh"

module onewire_uart_rom_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [7:0] data_byte, [63:8] rom_id
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] tx_byte, [8] slow_baud, [9] success,
                                  // [73:10] result_data, [79:74] zero
  output logic [0:0]  out_tuser   // [0] kind
);

  logic                       in_valid_r;
  logic [2:0]                 op_r;
  logic [7:0]                 data_r;
  logic [owrs_pkg::ROM_W-1:0] rom_r;
  owrs_pkg::state_t           state_r;
  owrs_pkg::state_t           state_nxt;
  logic                       res_valid;
  owrs_pkg::result_t          res;
  owrs_pkg::result_t          res_r;
  logic                       out_free;
  logic                       adv;
  logic                       in_acc;

  // Advance the held beat whenever the result register can take its output.
  assign adv       = in_valid_r && out_free;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser;
      data_r <= in_tdata[7:0];
      rom_r  <= in_tdata[63:8];
    end
  end

  owrs_step u_step (
    .st        (state_r),
    .op        (op_r),
    .data_byte (data_r),
    .rom_id    (rom_r),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  owrs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && res_valid),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_r      (res_r),
    .free       (out_free)
  );

  assign out_tdata = {6'd0, res_r.result_data, res_r.success, res_r.slow_baud, res_r.tx_byte};
  assign out_tuser = res_r.kind;

  `OWRS_ASSERT_IMP(a_done_no_tx, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[7:0] == owrs_pkg::BYTE_ZERO)
  `OWRS_ASSERT_IMP(a_tx_no_data, clk, rst_n, out_tvalid && !out_tuser[0], !out_tdata[9] && out_tdata[73:10] == 64'd0)
  `OWRS_ASSERT_IMP(a_reset_slow, clk, rst_n, out_tvalid && !out_tuser[0] && out_tdata[7:0] == owrs_pkg::BYTE_RESET, out_tdata[8])
  `OWRS_ASSERT_NXT(a_done_idle, clk, rst_n, adv && res_valid && res.kind, !state_r.busy)

endmodule

// ----- hdl/owrs_step.sv -----
// Next-state and result logic for one beat of the sequencer.
// Purely combinational; depends on owrs_pkg.
module owrs_step (
  input  owrs_pkg::state_t            st,
  input  logic [2:0]                  op,
  input  logic [7:0]                  data_byte,
  input  logic [owrs_pkg::ROM_W-1:0]  rom_id,
  output owrs_pkg::state_t            st_nxt,
  output logic                        res_valid,
  output owrs_pkg::result_t           res
);

  logic       send;
  logic       fin;
  logic       fin_ok;
  logic [63:0] fin_data;
  logic       presence;
  logic       echo_one;
  logic [6:0] s;
  logic [6:0] s_inc;
  logic [6:0] total;
  logic [5:0] idx;
  logic [6:0] ss;
  logic [5:0] sidx;
  logic       sbit;
  logic       sff;
  logic [7:0] cbyte;
  logic [7:0] tx;

  always_comb begin
    st_nxt    = st;
    send      = 1'b0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    fin_data  = '0;
    res_valid = 1'b0;
    res       = '0;
    tx        = owrs_pkg::BYTE_ZERO;
    presence  = (data_byte != owrs_pkg::BYTE_RESET);
    echo_one  = (data_byte == owrs_pkg::BYTE_ONE);
    s         = st.slot;
    s_inc     = s + 7'd1;
    idx       = 6'(s - 7'd8);
    total     = (st.cmd == owrs_pkg::OP_READ_ROM || st.cmd == owrs_pkg::OP_MATCH) ?
                owrs_pkg::SLOTS_ROM : owrs_pkg::SLOTS_BYTE;
    ss        = '0;
    sidx      = '0;
    sbit      = 1'b0;
    sff       = 1'b0;
    cbyte     = '0;

    case (op)
      owrs_pkg::OP_RESET, owrs_pkg::OP_WRITE, owrs_pkg::OP_READ,
      owrs_pkg::OP_READ_ROM, owrs_pkg::OP_SKIP_ROM, owrs_pkg::OP_MATCH: begin
        if (!st.busy) begin
          st_nxt.busy = 1'b1;
          st_nxt.cmd  = op;
          st_nxt.slot = '0;
          st_nxt.crc  = '0;
          if (op == owrs_pkg::OP_WRITE) begin
            st_nxt.shift = {56'd0, data_byte};
          end else if (op == owrs_pkg::OP_MATCH) begin
            st_nxt.shift = {8'd0, rom_id};
          end else begin
            st_nxt.shift = '0;
          end
          if (op == owrs_pkg::OP_WRITE || op == owrs_pkg::OP_READ) begin
            st_nxt.rst_slot = 1'b0;
            send = 1'b1;
          end else begin
            st_nxt.rst_slot = 1'b1;
            st_nxt.fast     = 1'b0;
            res_valid       = 1'b1;
            tx              = owrs_pkg::BYTE_RESET;
          end
        end
      end
      owrs_pkg::OP_ECHO: begin
        if (st.busy) begin
          if (st.rst_slot) begin
            st_nxt.rst_slot = 1'b0;
            st_nxt.fast     = presence;
            if (st.cmd == owrs_pkg::OP_RESET) begin
              fin    = 1'b1;
              fin_ok = presence;
            end else if (!presence) begin
              fin = 1'b1;
            end else begin
              st_nxt.slot = '0;
              send = 1'b1;
            end
          end else begin
            if (st.cmd == owrs_pkg::OP_READ && echo_one) begin
              st_nxt.shift[s[2:0]] = 1'b1;
            end
            if (st.cmd == owrs_pkg::OP_READ_ROM && s >= 7'd8) begin
              if (echo_one) begin
                st_nxt.shift[idx] = 1'b1;
              end
              if (idx < owrs_pkg::ID_BITS) begin
                st_nxt.crc = owrs_pkg::crc_step(st.crc, echo_one);
              end
            end
            st_nxt.slot = s_inc;
            if (s_inc < total) begin
              send = 1'b1;
            end else begin
              fin = 1'b1;
              if (st.cmd == owrs_pkg::OP_READ) begin
                fin_ok   = 1'b1;
                fin_data = {56'd0, st_nxt.shift[7:0]};
              end else if (st.cmd == owrs_pkg::OP_READ_ROM) begin
                fin_ok   = (st_nxt.shift[63:56] == st_nxt.crc);
                fin_data = st_nxt.shift;
              end else begin
                fin_ok = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Build the byte for the next slot from the updated state.
    if (send) begin
      ss   = st_nxt.slot;
      sidx = 6'(ss - 7'd8);
      if (st_nxt.cmd == owrs_pkg::OP_WRITE) begin
        sbit = st_nxt.shift[ss[2:0]];
      end else if (st_nxt.cmd == owrs_pkg::OP_READ) begin
        sff = 1'b1;
      end else if (ss < 7'd8) begin
        cbyte = owrs_pkg::command_byte(st_nxt.cmd);
        sbit  = cbyte[ss[2:0]];
      end else if (st_nxt.cmd == owrs_pkg::OP_READ_ROM) begin
        sff = 1'b1;
      end else if (sidx < owrs_pkg::ID_BITS) begin
        sbit       = st_nxt.shift[sidx];
        st_nxt.crc = owrs_pkg::crc_step(st_nxt.crc, sbit);
      end else begin
        sbit = st_nxt.crc[sidx[2:0]];
      end
      res_valid = 1'b1;
      tx        = (sff || sbit) ? owrs_pkg::BYTE_ONE : owrs_pkg::BYTE_ZERO;
    end

    if (fin) begin
      st_nxt.busy = 1'b0;
      res_valid   = 1'b1;
    end

    res.kind        = fin;
    res.tx_byte     = fin ? owrs_pkg::BYTE_ZERO : tx;
    res.slow_baud   = ~st_nxt.fast;
    res.success     = fin_ok;
    res.result_data = fin_data;
  end

endmodule

// ----- hdl/owrs_out_stage.sv -----
// Result register for the sequencer's master-side stream.
// Depends on owrs_pkg for the result layout.
module owrs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  owrs_pkg::result_t res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output owrs_pkg::result_t res_r,
  output logic              free
);

  logic valid_r;
  logic valid_nxt;

  assign free       = !valid_r || out_tready;
  assign valid_nxt  = load || (valid_r && !out_tready);
  assign out_tvalid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload carries no reset; load only into a free slot.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ----- tb/onewire_uart_rom_sequencer_core_test.sv -----
// Self-checking bench for onewire_uart_rom_sequencer_core: bus reset, byte and ROM commands,
// driven as command and echo beats. A scoreboard class predicts every result beat.
// Depends on owrs_pkg and the core RTL only.

class owrs_scoreboard;
  // mirror of the sequencer
  bit                 busy;
  logic [2:0]         cmd;
  logic [6:0]         slot;
  logic [63:0]        shreg;
  logic [7:0]         crc;
  bit                 fast;
  bit                 await_presence;
  owrs_pkg::result_t  pending[$];
  int                 n_in, n_out, n_bad, n_done, n_crc_ok, n_present;

  // Reflected Dallas CRC-8, one bit at a time.
  static function logic [7:0] crc8_bit(logic [7:0] c, logic b);
    logic       mix;
    logic [7:0] r;
    mix = c[0] ^ b;
    r = c >> 1;
    if (mix) r = r ^ 8'h8C;
    return r;
  endfunction

  function void queue_result(bit k, logic [7:0] tx, bit ok, logic [63:0] d);
    owrs_pkg::result_t r;
    r.kind = k;
    r.tx_byte = tx;
    r.slow_baud = !fast;
    r.success = ok;
    r.result_data = d;
    pending.push_back(r);
  endfunction

  function void close_command(bit ok, logic [63:0] d);
    busy = 1'b0;
    n_done++;
    queue_result(1'b1, owrs_pkg::BYTE_ZERO, ok, d);
  endfunction

  function void next_slot_byte();
    logic [7:0] cb;
    bit         b;
    int         idx;
    b = 1'b0;
    if (cmd == owrs_pkg::OP_READ || (cmd == owrs_pkg::OP_READ_ROM && slot >= 7'd8)) begin
      queue_result(1'b0, owrs_pkg::BYTE_ONE, 1'b0, 64'd0);
      return;
    end
    if (cmd == owrs_pkg::OP_WRITE) begin
      b = shreg[slot[2:0]];
    end else if (slot < 7'd8) begin
      case (cmd)
        owrs_pkg::OP_READ_ROM: cb = owrs_pkg::CMD_READ_ROM;
        owrs_pkg::OP_SKIP_ROM: cb = owrs_pkg::CMD_SKIP_ROM;
        default:               cb = owrs_pkg::CMD_MATCH;
      endcase
      b = cb[slot[2:0]];
    end else begin
      // id bits feed the CRC as they go out, then the CRC itself follows
      idx = int'(slot) - 8;
      if (idx < 56) begin
        b = shreg[idx];
        crc = crc8_bit(crc, b);
      end else begin
        b = crc[idx - 56];
      end
    end
    queue_result(1'b0, b ? owrs_pkg::BYTE_ONE : owrs_pkg::BYTE_ZERO, 1'b0, 64'd0);
  endfunction

  function void note_input(logic [2:0] op, logic [7:0] data, logic [55:0] rom);
    bit         present;
    bit         b;
    int         idx;
    logic [6:0] total;
    n_in++;
    if (op == owrs_pkg::OP_ECHO) begin
      if (!busy) return;
      if (await_presence) begin
        present = (data != owrs_pkg::BYTE_RESET);
        await_presence = 1'b0;
        fast = present;
        if (present) n_present++;
        if (cmd == owrs_pkg::OP_RESET) close_command(present, 64'd0);
        else if (!present) close_command(1'b0, 64'd0);
        else begin
          slot = 7'd0;
          next_slot_byte();
        end
        return;
      end
      if (cmd == owrs_pkg::OP_READ && data == owrs_pkg::BYTE_ONE) shreg[slot[2:0]] = 1'b1;
      if (cmd == owrs_pkg::OP_READ_ROM && slot >= 7'd8) begin
        idx = int'(slot) - 8;
        b = (data == owrs_pkg::BYTE_ONE);
        if (b) shreg[idx] = 1'b1;
        if (idx < 56) crc = crc8_bit(crc, b);
      end
      slot = slot + 7'd1;
      total = (cmd == owrs_pkg::OP_READ_ROM || cmd == owrs_pkg::OP_MATCH) ?
              owrs_pkg::SLOTS_ROM : owrs_pkg::SLOTS_BYTE;
      if (slot < total) begin
        next_slot_byte();
      end else if (cmd == owrs_pkg::OP_READ) begin
        close_command(1'b1, {56'd0, shreg[7:0]});
      end else if (cmd == owrs_pkg::OP_READ_ROM) begin
        if (shreg[63:56] == crc) n_crc_ok++;
        close_command(shreg[63:56] == crc, shreg);
      end else begin
        close_command(1'b1, 64'd0);
      end
      return;
    end
    // drop reserved codes and commands that arrive mid-command
    if (op > owrs_pkg::OP_ECHO || busy) return;
    busy = 1'b1;
    cmd = op;
    slot = 7'd0;
    crc = 8'd0;
    shreg = (op == owrs_pkg::OP_WRITE) ? {56'd0, data} :
            (op == owrs_pkg::OP_MATCH) ? {8'd0, rom} : 64'd0;
    if (op == owrs_pkg::OP_WRITE || op == owrs_pkg::OP_READ) begin
      await_presence = 1'b0;
      next_slot_byte();
    end else begin
      await_presence = 1'b1;
      fast = 1'b0;
      queue_result(1'b0, owrs_pkg::BYTE_RESET, 1'b0, 64'd0);
    end
  endfunction

  function void flag(string msg);
    n_bad++;
    if (n_bad <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_result(owrs_pkg::result_t got);
    owrs_pkg::result_t want;
    n_out++;
    if (pending.size() == 0) begin
      flag($sformatf("result beat %0d with nothing pending: kind=%0d tx=%02h data=%016h",
                     n_out, got.kind, got.tx_byte, got.result_data));
      return;
    end
    want = pending.pop_front();
    if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
        got.slow_baud !== want.slow_baud || got.success !== want.success ||
        got.result_data !== want.result_data)
      flag($sformatf({"beat %0d want kind=%0d tx=%02h slow=%0d ok=%0d data=%016h,",
                      " got kind=%0d tx=%02h slow=%0d ok=%0d data=%016h"},
                     n_out, want.kind, want.tx_byte, want.slow_baud, want.success,
                     want.result_data, got.kind, got.tx_byte, got.slow_baud, got.success,
                     got.result_data));
  endfunction
endclass

module onewire_uart_rom_sequencer_core_test;
  localparam logic [2:0] OP_RESERVED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [55:0] rom;
  } stim_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = 64'd0;
  logic [2:0]  in_tuser = 3'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;

  owrs_scoreboard board;
  stim_item_t     stim_q[$];
  bit             stall_hold = 1'b0;
  bit             pressure_done = 1'b0;
  int             quiet_cycles = 0;

  onewire_uart_rom_sequencer_core dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [55:0] rand_rom();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[55:0];
  endfunction

  function automatic logic [7:0] zero_echo();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 254)) : owrs_pkg::BYTE_ZERO;
  endfunction

  function automatic void push_item(logic [2:0] op, logic [7:0] data, logic [55:0] rom);
    stim_item_t it;
    it.op = op;
    it.data = data;
    it.rom = rom;
    stim_q.push_back(it);
  endfunction

  // Commands offered mid-command; the core must ignore them.
  function automatic void maybe_busy_noise(int pct);
    logic [2:0] op;
    if ($urandom_range(0, 99) >= pct) return;
    op = 3'($urandom_range(0, 6));
    if (op == owrs_pkg::OP_ECHO) op = OP_RESERVED;
    push_item(op, 8'($urandom_range(0, 255)), rand_rom());
  endfunction

  // One command followed by the echoes that complete it.
  function automatic void queue_sequence(logic [2:0] op, logic [7:0] data, logic [55:0] rom,
                                         bit present, bit ones, int noise_pct);
    logic [63:0] code;
    logic [7:0]  c, e;
    int          slots, i;
    code = {$urandom(), $urandom()};
    if ($urandom_range(0, 9) < 6) begin
      c = 8'd0;
      for (i = 0; i < 56; i++) c = board.crc8_bit(c, code[i]);
      code[63:56] = c;
    end
    push_item(op, data, rom);
    if (op != owrs_pkg::OP_WRITE && op != owrs_pkg::OP_READ) begin
      if (present) begin
        e = 8'($urandom_range(0, 255));
        if (e == owrs_pkg::BYTE_RESET) e = owrs_pkg::BYTE_ZERO;
      end else begin
        e = owrs_pkg::BYTE_RESET;
      end
      maybe_busy_noise(noise_pct);
      push_item(owrs_pkg::OP_ECHO, e, rand_rom());
      if (!present || op == owrs_pkg::OP_RESET) return;
    end
    slots = (op == owrs_pkg::OP_READ_ROM || op == owrs_pkg::OP_MATCH) ? 72 : 8;
    for (i = 0; i < slots; i++) begin
      maybe_busy_noise(noise_pct);
      if (op == owrs_pkg::OP_READ)
        e = (ones || $urandom_range(0, 1)) ? owrs_pkg::BYTE_ONE : zero_echo();
      else if (op == owrs_pkg::OP_READ_ROM && i >= 8)
        e = code[i - 8] ? owrs_pkg::BYTE_ONE : zero_echo();
      else e = 8'($urandom_range(0, 255));
      push_item(owrs_pkg::OP_ECHO, e, rand_rom());
    end
  endfunction

  task automatic drive_items();
    stim_item_t it;
    int         burst, gap;
    while (stim_q.size() != 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && stim_q.size() != 0) begin
        it = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {it.rom, it.data};
        in_tuser  <= it.op;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        burst--;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 4);
        8:          gap = $urandom_range(5, 20);
        default:    gap = $urandom_range(30, 60);
      endcase
      // keep offering while the receiver is held off
      if (stall_hold) gap = 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    owrs_pkg::result_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.kind = out_tuser[0];
        seen.tx_byte = out_tdata[7:0];
        seen.slow_baud = out_tdata[8];
        seen.success = out_tdata[9];
        seen.result_data = out_tdata[73:10];
        board.check_result(seen);
      end
      if (in_tvalid && in_tready) board.note_input(in_tuser, in_tdata[7:0], in_tdata[63:8]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : rx_pattern
    int cyc;
    bit rdy;
    cyc = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && board.n_in >= 400) begin
        // hold off long enough for the core to back up its input
        pressure_done = 1'b1;
        stall_hold = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold = 1'b0;
      end
      cyc++;
      case ((cyc / 97) % 4)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ((cyc % 3) == 0);
        default: rdy = $urandom_range(0, 1);
      endcase
      out_tready <= rdy;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("no beat for %0d cycles, %0d results outstanding", quiet_cycles,
             board.pending.size());
    $display("FAIL");
    $finish;
  end

  initial begin : main
    logic [2:0] op;
    int         pick;
    board = new();

    // directed: idle noise, ROM commands with no presence, slow-rate write,
    // presence detect, read of all ones
    push_item(owrs_pkg::OP_ECHO, owrs_pkg::BYTE_ONE, 56'd0);
    push_item(OP_RESERVED, 8'hFF, '1);
    queue_sequence(owrs_pkg::OP_READ_ROM, 8'hFF, '1, 1'b0, 1'b0, 0);
    queue_sequence(owrs_pkg::OP_MATCH, 8'h00, '1, 1'b0, 1'b0, 0);
    queue_sequence(owrs_pkg::OP_SKIP_ROM, 8'h00, 56'd0, 1'b0, 1'b0, 0);
    queue_sequence(owrs_pkg::OP_WRITE, 8'hFF, 56'd0, 1'b1, 1'b0, 10);
    queue_sequence(owrs_pkg::OP_RESET, 8'h00, 56'd0, 1'b1, 1'b0, 0);
    queue_sequence(owrs_pkg::OP_READ, 8'h00, 56'd0, 1'b1, 1'b1, 0);

    while (stim_q.size() < 1240) begin
      if ($urandom_range(0, 99) < 15)
        push_item($urandom_range(0, 1) ? owrs_pkg::OP_ECHO : OP_RESERVED,
                  8'($urandom_range(0, 255)), rand_rom());
      pick = $urandom_range(0, 99);
      if (pick < 15)      op = owrs_pkg::OP_RESET;
      else if (pick < 35) op = owrs_pkg::OP_WRITE;
      else if (pick < 55) op = owrs_pkg::OP_READ;
      else if (pick < 70) op = owrs_pkg::OP_READ_ROM;
      else if (pick < 80) op = owrs_pkg::OP_SKIP_ROM;
      else                op = owrs_pkg::OP_MATCH;
      queue_sequence(op, 8'($urandom_range(0, 255)), rand_rom(),
                     $urandom_range(0, 99) < 85, $urandom_range(0, 19) == 0, 4);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_items();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input beats and %0d result beats, %0d commands completed",
             board.n_in, board.n_out, board.n_done);
    $display("saw %0d presence detects, %0d ROM reads with a good CRC, %0d mismatches",
             board.n_present, board.n_crc_ok, board.n_bad);
    if (board.n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
